>>> rtl/spaatd_pkg.sv
// Shared types, constants and saturation helpers for the sparse A*A'*B block.
package spaatd_pkg;

    localparam int MAX_ROWS_DEF = 256;
    localparam int MAX_COLS_DEF = 16;
    localparam int MAX_NZ_DEF   = 64;

    localparam logic signed [31:0] ALPHA_RST = 32'sh0001_0000;
    localparam logic signed [31:0] BETA_RST  = 32'sh0000_0000;
    localparam logic [8:0]         ROWS_RST  = 9'd256;
    localparam logic [4:0]         COLS_RST  = 5'd16;

    // cycle in a step at which the multiplier result is ready
    localparam logic [2:0] PH_DONE = 3'd4;

    typedef enum logic [1:0] {
        OP_LOAD_B = 2'd0,
        OP_LOAD_C = 2'd1,
        OP_A_NZ   = 2'd2,
        OP_READ_C = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_ALPHA = 2'd0,
        REG_BETA  = 2'd1,
        REG_ROWS  = 2'd2,
        REG_COLS  = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LDC,
        S_NZ,
        S_COEF,
        S_FIN
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [7:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
        logic               column_last;
    } t_in;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               saturated;
    } t_out;

    function automatic logic ovf32(input logic signed [65:0] x);
        return (x > 66'sh0_7FFF_FFFF) || (x < -66'sh0_8000_0000);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (ovf32(x)) begin
            return x[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return x[31:0];
    endfunction

    function automatic logic ovf48(input logic signed [65:0] x);
        return (x > 66'sh0_7FFF_FFFF_FFFF) || (x < -66'sh0_8000_0000_0000);
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [65:0] x);
        if (ovf48(x)) begin
            return x[65] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
        end
        return x[47:0];
    endfunction

endpackage

>>> rtl/spaatd_cell.sv
// One accumulator cell of the rotating temporary-vector chain.
module spaatd_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear,
    input  logic               i_shift,
    input  logic signed [47:0] i_din,
    output logic signed [47:0] o_q
);

    logic signed [47:0] r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_val <= '0;
        end else if (i_shift) begin
            r_val <= i_din;
        end
    end

    assign o_q = r_val;

endmodule

>>> rtl/spaatd_mac.sv
// Three-stage Q16.16 multiplier, rounding half away from zero.
module spaatd_mac (
    input  logic               i_clk,
    input  logic signed [47:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_p
);

    logic        r_neg1, r_neg2;
    logic [47:0] r_ma;
    logic [31:0] r_mb;
    logic [63:0] r_hi;
    logic [47:0] r_lo;
    logic signed [63:0] r_p;
    logic [63:0] sum;

    assign sum = r_hi + 64'((r_lo + 48'h8000) >> 16);

    always_ff @(posedge i_clk) begin
        r_neg1 <= i_a[47] ^ i_b[31];
        r_ma   <= i_a[47] ? 48'(-i_a) : 48'(i_a);
        r_mb   <= i_b[31] ? 32'(-i_b) : 32'(i_b);
        r_neg2 <= r_neg1;
        r_hi   <= 64'(r_ma[47:16]) * 64'(r_mb);
        r_lo   <= 48'(r_ma[15:0]) * 48'(r_mb);
        r_p    <= r_neg2 ? -$signed(sum) : $signed(sum);
    end

    assign o_p = r_p;

endmodule

>>> rtl/sparse_aat_times_dense_top.sv
// Top level: C = alpha*A*A'*B + beta*C with a rotating chain of accumulator cells.
//
// channel   | direction | handshake
// request   | in        | start, busy; taken when start & !busy
// response  | out       | o_rsp_valid, one cycle, no back-pressure
// config    | in        | i_cfg_we, i_cfg_idx, i_cfg_data
//
// Load B: written when the request is taken. Read C: result in the cycle after the request.
// Load C: value times beta, written to C. A nonzero: B row times value over the active columns, into the cells.
// Column end: per kept nonzero, coefficient alpha*a, then coefficient times each cell added into its C row.
// Step time is set by the 3-stage shared multiplier behind the registered B/C memory reads.
// Synchronous reset; the response side cannot stall.
module sparse_aat_times_dense_top #(
    parameter int MAX_ROWS            = spaatd_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS            = spaatd_pkg::MAX_COLS_DEF,
    parameter int MAX_COLUMN_NONZEROS = spaatd_pkg::MAX_NZ_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  spaatd_pkg::t_in   i_req,
    output logic              o_rsp_valid,
    output spaatd_pkg::t_out  o_rsp,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data
);

    localparam int MEM_D = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(MEM_D);
    localparam int JW    = $clog2(MAX_COLS + 1);
    localparam int KW    = $clog2(MAX_COLUMN_NONZEROS + 1);
    localparam int KIW   = (MAX_COLUMN_NONZEROS > 1) ? $clog2(MAX_COLUMN_NONZEROS) : 1;

    logic signed [31:0] r_alpha, r_beta;
    logic [8:0]         r_rows;
    logic [4:0]         r_cols;

    spaatd_pkg::t_state r_state, n_state;
    spaatd_pkg::t_in    r_req, n_req;
    logic               r_ok, n_ok;
    logic [AW-1:0]      r_base, n_base;
    logic [JW-1:0]      r_j, n_j;
    logic [2:0]         r_ph, n_ph;
    logic [KW-1:0]      r_cnt, n_cnt, r_k, n_k;
    logic signed [31:0] r_coef, n_coef;
    logic               r_sat, n_sat;

    logic signed [31:0] b_mem [MEM_D];
    logic signed [31:0] c_mem [MEM_D];
    logic [39:0]        nz_mem [MAX_COLUMN_NONZEROS];
    logic signed [31:0] r_b_rd, r_c_rd;
    logic [39:0]        r_nz_rd;

    logic               accept, row_ok, col_ok, take;
    logic [AW-1:0]      in_base, in_addr, pass_addr, nz_base, c_raddr, c_waddr;
    logic               c_we;
    logic signed [31:0] c_wdata;
    logic               step_on, pass_last;
    logic signed [47:0] mac_a;
    logic signed [31:0] mac_b;
    logic signed [63:0] mac_p;
    logic signed [65:0] p_ext;
    logic               shift, clear;
    logic signed [47:0] head_new;
    logic signed [47:0] cell_q [MAX_COLS];

    assign busy      = r_state != spaatd_pkg::S_IDLE;
    assign accept    = start && !busy;
    assign row_ok    = (32'(i_req.row) < 32'(r_rows)) && (32'(i_req.row) < MAX_ROWS);
    assign col_ok    = (32'(i_req.col) < 32'(r_cols)) && (32'(i_req.col) < MAX_COLS);
    assign take      = row_ok && (32'(r_cnt) < MAX_COLUMN_NONZEROS);
    assign in_base   = AW'(32'(i_req.row) * MAX_COLS);
    assign in_addr   = in_base + AW'(i_req.col);
    assign nz_base   = AW'(32'(r_nz_rd[39:32]) * MAX_COLS);
    assign pass_addr = r_base + AW'(r_j);
    assign c_raddr   = busy ? pass_addr : in_addr;
    assign step_on   = 32'(r_j) < 32'(r_cols);
    assign pass_last = 32'(r_j) == (MAX_COLS - 1);
    assign p_ext     = 66'(mac_p);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= spaatd_pkg::ALPHA_RST;
            r_beta  <= spaatd_pkg::BETA_RST;
            r_rows  <= spaatd_pkg::ROWS_RST;
            r_cols  <= spaatd_pkg::COLS_RST;
        end else if (i_cfg_we) begin
            case (spaatd_pkg::t_reg'(i_cfg_idx))
                spaatd_pkg::REG_ALPHA: r_alpha <= i_cfg_data;
                spaatd_pkg::REG_BETA:  r_beta  <= i_cfg_data;
                spaatd_pkg::REG_ROWS:  r_rows  <= i_cfg_data[8:0];
                spaatd_pkg::REG_COLS:  r_cols  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (accept && i_req.op == spaatd_pkg::OP_LOAD_B && row_ok && col_ok) begin
            b_mem[in_addr] <= i_req.value;
        end
        r_b_rd <= b_mem[pass_addr];
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            c_mem[c_waddr] <= c_wdata;
        end
        r_c_rd <= c_mem[c_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_req.op == spaatd_pkg::OP_A_NZ && take) begin
            nz_mem[r_cnt[KIW-1:0]] <= {i_req.row, i_req.value};
        end
        r_nz_rd <= nz_mem[r_k[KIW-1:0]];
    end

    spaatd_mac u_mac (
        .i_clk (i_clk),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_p   (mac_p)
    );

    // temporary vector: cell 0 is the head, data moves toward it
    for (genvar gi = 0; gi < MAX_COLS; gi++) begin : g_cell
        logic signed [47:0] din;
        if (gi == MAX_COLS - 1) begin : g_tail
            assign din = head_new;
        end else begin : g_mid
            assign din = cell_q[gi + 1];
        end
        spaatd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (clear),
            .i_shift (shift),
            .i_din   (din),
            .o_q     (cell_q[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spaatd_pkg::S_IDLE;
            r_ph    <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_cnt   <= '0;
            r_sat   <= 1'b0;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_j     <= n_j;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
            r_sat   <= n_sat;
            r_ok    <= n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_base <= n_base;
        r_coef <= n_coef;
    end

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_ok     = r_ok;
        n_base   = r_base;
        n_j      = r_j;
        n_ph     = r_ph;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_coef   = r_coef;
        n_sat    = r_sat;
        c_we     = 1'b0;
        c_waddr  = pass_addr;
        c_wdata  = spaatd_pkg::sat32(p_ext);
        shift    = 1'b0;
        clear    = 1'b0;
        head_new = cell_q[0];
        mac_a    = '0;
        mac_b    = '0;

        case (r_state)
            spaatd_pkg::S_LDC: begin
                mac_a = {{16{r_beta[31]}}, r_beta};
                mac_b = r_req.value;
            end
            spaatd_pkg::S_NZ: begin
                mac_a = {{16{r_b_rd[31]}}, r_b_rd};
                mac_b = r_req.value;
            end
            spaatd_pkg::S_COEF: begin
                mac_a = {{16{r_alpha[31]}}, r_alpha};
                mac_b = r_nz_rd[31:0];
            end
            spaatd_pkg::S_FIN: begin
                mac_a = cell_q[0];
                mac_b = r_coef;
            end
            default: ;
        endcase

        case (r_state)
            spaatd_pkg::S_IDLE: begin
                if (accept) begin
                    n_req  = i_req;
                    n_ph   = '0;
                    n_j    = '0;
                    n_k    = '0;
                    n_ok   = row_ok && col_ok;
                    n_base = in_addr;
                    case (i_req.op)
                        spaatd_pkg::OP_READ_C: n_state = spaatd_pkg::S_READ;
                        spaatd_pkg::OP_LOAD_C: begin
                            if (row_ok && col_ok) begin
                                n_state = spaatd_pkg::S_LDC;
                            end
                        end
                        spaatd_pkg::OP_A_NZ: begin
                            if (take) begin
                                n_base  = in_base;
                                n_cnt   = r_cnt + 1'b1;
                                n_state = spaatd_pkg::S_NZ;
                            end else if (i_req.column_last) begin
                                if (r_cnt == '0) begin
                                    clear = 1'b1;
                                end else begin
                                    n_state = spaatd_pkg::S_COEF;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            spaatd_pkg::S_READ: begin
                n_state = spaatd_pkg::S_IDLE;
            end
            spaatd_pkg::S_LDC: begin
                n_ph = r_ph + 1'b1;
                if (r_ph == spaatd_pkg::PH_DONE) begin
                    c_we    = 1'b1;
                    c_waddr = r_base;
                    c_wdata = spaatd_pkg::sat32(p_ext);
                    n_sat   = r_sat | spaatd_pkg::ovf32(p_ext);
                    n_state = spaatd_pkg::S_IDLE;
                end
            end
            spaatd_pkg::S_NZ: begin
                n_ph = r_ph + 1'b1;
                if (!step_on || r_ph == spaatd_pkg::PH_DONE) begin
                    shift = 1'b1;
                    n_ph  = '0;
                    n_j   = r_j + 1'b1;
                    if (step_on) begin
                        head_new = spaatd_pkg::sat48(66'(cell_q[0]) + p_ext);
                        n_sat    = r_sat | spaatd_pkg::ovf48(66'(cell_q[0]) + p_ext);
                    end
                    if (pass_last) begin
                        n_j = '0;
                        n_k = '0;
                        if (r_req.column_last) begin
                            n_state = spaatd_pkg::S_COEF;
                        end else begin
                            n_state = spaatd_pkg::S_IDLE;
                        end
                    end
                end
            end
            spaatd_pkg::S_COEF: begin
                n_ph = r_ph + 1'b1;
                if (r_ph == spaatd_pkg::PH_DONE) begin
                    n_coef  = spaatd_pkg::sat32(p_ext);
                    n_sat   = r_sat | spaatd_pkg::ovf32(p_ext);
                    n_base  = nz_base;
                    n_j     = '0;
                    n_ph    = '0;
                    n_state = spaatd_pkg::S_FIN;
                end
            end
            spaatd_pkg::S_FIN: begin
                n_ph = r_ph + 1'b1;
                if (!step_on || r_ph == spaatd_pkg::PH_DONE) begin
                    shift = 1'b1;
                    n_ph  = '0;
                    n_j   = r_j + 1'b1;
                    if (step_on) begin
                        c_we    = 1'b1;
                        c_wdata = spaatd_pkg::sat32(66'(r_c_rd) + p_ext);
                        n_sat   = r_sat | spaatd_pkg::ovf32(66'(r_c_rd) + p_ext);
                    end
                    if (pass_last) begin
                        n_j = '0;
                        n_k = r_k + 1'b1;
                        if (r_k + 1'b1 == r_cnt) begin
                            clear   = 1'b1;
                            n_cnt   = '0;
                            n_state = spaatd_pkg::S_IDLE;
                        end else begin
                            n_state = spaatd_pkg::S_COEF;
                        end
                    end
                end
            end
            default: n_state = spaatd_pkg::S_IDLE;
        endcase
    end

    assign o_rsp_valid          = r_state == spaatd_pkg::S_READ;
    assign o_rsp.read_value     = r_ok ? r_c_rd : 32'sd0;
    assign o_rsp.saturated      = r_sat;

    a_read_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.op == spaatd_pkg::OP_READ_C) |=> o_rsp_valid)
        else $error("read request gave no response");

    a_one_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |=> !o_rsp_valid)
        else $error("response held past one cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= MAX_COLUMN_NONZEROS)
        else $error("nonzero count overflow");

    a_sat_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |=> r_sat)
        else $error("saturation flag cleared");

endmodule
